[rtl/core/vqda_pkg.sv]
// Shared types and constants of the virtqueue descriptor allocator.
`default_nettype none
package vqda_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FREED = 2'd3
    } status_t;

    // Item function codes
    localparam logic FUNC_SUBMIT  = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Configuration register indexes
    localparam logic [0:0] CFG_HEADER_BASE = 1'b0;
    localparam logic [0:0] CFG_STATUS_BASE = 1'b1;

    // Descriptor flag bits
    localparam logic [1:0] FLAG_NEXT  = 2'b01;
    localparam logic [1:0] FLAG_WRITE = 2'b10;

    // Descriptor lengths
    localparam logic [10:0] HEADER_LEN = 11'd16;
    localparam logic [10:0] BLOCK_LEN  = 11'd1024;
    localparam logic [10:0] STATUS_LEN = 11'd1;

    localparam int SLOT_SHIFT  = 4;  // sixteen bytes per slot
    localparam int CHAIN_LEN   = 3;  // descriptors per request
    localparam int MAX_RESULTS = 8;  // cap on a release walk
    localparam int HEAD_W      = 4;  // width of the head index field

    typedef struct packed {
        status_t      status;
        logic [3:0]   desc_index;
        logic [63:0]  desc_addr;
        logic [10:0]  desc_len;
        logic [1:0]   desc_flags;
        logic [2:0]   desc_next;
        logic [2:0]   avail_slot;
        logic         request_type;
        logic [32:0]  sector;
        logic         last;
    } res_t;

endpackage
`default_nettype wire

[rtl/core/vqda_ifs.sv]
// Valid/ready channel interfaces for submit/release items and results.
`default_nettype none
interface vqda_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic        is_write;
    logic [31:0] block_number;
    logic [63:0] data_addr;
    logic [3:0]  head_index;

    modport source (output valid, func, is_write, block_number, data_addr, head_index,
                    input ready);
    modport sink   (input valid, func, is_write, block_number, data_addr, head_index,
                    output ready);
endinterface

interface vqda_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  desc_index;
    logic [63:0] desc_addr;
    logic [10:0] desc_len;
    logic [1:0]  desc_flags;
    logic [2:0]  desc_next;
    logic [2:0]  avail_slot;
    logic        request_type;
    logic [32:0] sector;
    logic        last;

    modport source (output valid, status, desc_index, desc_addr, desc_len, desc_flags,
                    desc_next, avail_slot, request_type, sector, last,
                    input ready);
    modport sink   (input valid, status, desc_index, desc_addr, desc_len, desc_flags,
                    desc_next, avail_slot, request_type, sector, last,
                    output ready);
endinterface
`default_nettype wire

[rtl/core/vqda_desc_mem.sv]
// Descriptor table: one write port, one read port, registered read data.
`default_nettype none
module vqda_desc_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 80
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/core/vqda_free_map.sv]
// Free descriptor bitmap with lowest-free search under a mask.
`default_nettype none
module vqda_free_map #(
    parameter int QUEUE_SIZE = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [QUEUE_SIZE-1:0]         mask,
    output logic                               found,
    output logic      [$clog2(QUEUE_SIZE)-1:0] pos,
    input  wire logic                          upd_en,
    input  wire logic [$clog2(QUEUE_SIZE)-1:0] upd_idx,
    input  wire logic                          upd_val,
    input  wire logic [$clog2(QUEUE_SIZE)-1:0] rd_idx,
    output logic                               rd_bit
);

    localparam int IDX_W = $clog2(QUEUE_SIZE);

    logic [QUEUE_SIZE-1:0] free_reg;
    logic [QUEUE_SIZE-1:0] avail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
        end
        else if (upd_en)
        begin
            free_reg[upd_idx] <= upd_val;
        end
    end

    // priority encode, lowest index wins
    always_comb
    begin
        avail = free_reg & ~mask;
        pos   = '0;
        for (int i = QUEUE_SIZE - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                pos = IDX_W'(i);
            end
        end
    end

    assign found  = |avail;
    // indexes past the end read as free; the sequencer range-checks first
    assign rd_bit = ({1'b0, rd_idx} < (IDX_W + 1)'(QUEUE_SIZE)) ? free_reg[rd_idx] : 1'b1;

endmodule
`default_nettype wire

[rtl/core/vqda_ctrl.sv]
// Request sequencer: descriptor allocation, chain writes, release walk, result register.
`default_nettype none
module vqda_ctrl #(
    parameter int QUEUE_SIZE = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic [63:0]                            header_base,
    input  wire logic [63:0]                            status_base,
    vqda_in_if.sink                                     in_ch,
    vqda_out_if.source                                  out_ch,
    // free map
    output logic      [QUEUE_SIZE-1:0]                  fm_mask,
    input  wire logic                                   fm_found,
    input  wire logic [$clog2(QUEUE_SIZE)-1:0]          fm_pos,
    output logic                                        fm_upd_en,
    output logic      [$clog2(QUEUE_SIZE)-1:0]          fm_upd_idx,
    output logic                                        fm_upd_val,
    output logic      [$clog2(QUEUE_SIZE)-1:0]          fm_rd_idx,
    input  wire logic                                   fm_rd_bit,
    // descriptor memory
    output logic                                        mem_we,
    output logic      [$clog2(QUEUE_SIZE)-1:0]          mem_waddr,
    output logic      [77+$clog2(QUEUE_SIZE)-1:0]       mem_wdata,
    output logic                                        mem_re,
    output logic      [$clog2(QUEUE_SIZE)-1:0]          mem_raddr,
    input  wire logic [77+$clog2(QUEUE_SIZE)-1:0]       mem_rdata
);

    localparam int IDX_W  = $clog2(QUEUE_SIZE);
    localparam int CUR_W  = (IDX_W > vqda_pkg::HEAD_W) ? IDX_W : vqda_pkg::HEAD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_FULL,
        S_SUBMIT,
        S_REL_CHK,
        S_REL_OUT
    } state_t;

    state_t               state_reg,     state_next;
    logic [1:0]           k_reg,         k_next;
    logic [IDX_W-1:0]     idx_reg [vqda_pkg::CHAIN_LEN];
    logic [IDX_W-1:0]     idx_next [vqda_pkg::CHAIN_LEN];
    logic [QUEUE_SIZE-1:0] taken_reg,    taken_next;
    logic [CUR_W-1:0]     cur_reg,       cur_next;
    logic [2:0]           n_reg,         n_next;
    logic                 is_write_reg,  is_write_next;
    logic [32:0]          sector_reg,    sector_next;
    logic [63:0]          data_reg,      data_next;
    logic [15:0]          avail_cnt_reg, avail_cnt_next;
    logic [IDX_W-1:0]     slot_reg,      slot_next;
    logic                 out_valid_reg, out_valid_next;
    vqda_pkg::res_t       out_reg,       out_next;

    logic                 out_free;
    logic                 cur_in_range;
    logic [63:0]          base_sel;
    logic [63:0]          slot_addr;
    logic [63:0]          wr_addr;
    logic [10:0]          wr_len;
    logic [1:0]           wr_flags;
    logic [IDX_W-1:0]     wr_next;
    logic [1:0]           rd_flags;
    logic [IDX_W-1:0]     rd_next;
    logic                 rd_stop;

    assign out_free     = !out_valid_reg || out_ch.ready;
    assign cur_in_range = ({1'b0, cur_reg} < (CUR_W + 1)'(QUEUE_SIZE));

    assign rd_flags = mem_rdata[IDX_W +: 2];
    assign rd_next  = mem_rdata[IDX_W-1:0];
    assign rd_stop  = !rd_flags[0] || (n_reg == 3'(vqda_pkg::MAX_RESULTS - 1));

    // descriptor contents for submit step k
    assign base_sel  = (k_reg == 2'd0) ? header_base : status_base;
    assign slot_addr = base_sel + (64'(idx_reg[0]) << vqda_pkg::SLOT_SHIFT);

    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                wr_addr  = slot_addr;
                wr_len   = vqda_pkg::HEADER_LEN;
                wr_flags = vqda_pkg::FLAG_NEXT;
                wr_next  = idx_reg[1];
            end
            2'd1:
            begin
                wr_addr  = data_reg;
                wr_len   = vqda_pkg::BLOCK_LEN;
                wr_flags = is_write_reg ? vqda_pkg::FLAG_NEXT
                                        : (vqda_pkg::FLAG_NEXT | vqda_pkg::FLAG_WRITE);
                wr_next  = idx_reg[2];
            end
            default:
            begin
                wr_addr  = slot_addr;
                wr_len   = vqda_pkg::STATUS_LEN;
                wr_flags = vqda_pkg::FLAG_WRITE;
                wr_next  = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        taken_next     = taken_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        is_write_next  = is_write_reg;
        sector_next    = sector_reg;
        data_next      = data_reg;
        avail_cnt_next = avail_cnt_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_next       = out_reg;

        mem_we     = 1'b0;
        mem_waddr  = idx_reg[k_reg];
        mem_wdata  = {wr_addr, wr_len, wr_flags, wr_next};
        mem_re     = 1'b0;
        mem_raddr  = cur_reg[IDX_W-1:0];
        fm_upd_en  = 1'b0;
        fm_upd_idx = idx_reg[k_reg];
        fm_upd_val = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    is_write_next = in_ch.is_write;
                    sector_next   = {in_ch.block_number, 1'b0};
                    data_next     = in_ch.data_addr;
                    cur_next      = CUR_W'(in_ch.head_index);
                    n_next        = '0;
                    taken_next    = '0;
                    k_next        = '0;
                    state_next    = (in_ch.func == vqda_pkg::FUNC_RELEASE) ? S_REL_CHK
                                                                           : S_FIND;
                end
            end

            S_FIND:
            begin
                if (!fm_found)
                begin
                    state_next = S_FULL;
                end
                else
                begin
                    idx_next[k_reg] = fm_pos;
                    taken_next      = taken_reg | (QUEUE_SIZE'(1) << fm_pos);
                    if (k_reg == 2'(vqda_pkg::CHAIN_LEN - 1))
                    begin
                        k_next     = '0;
                        state_next = S_SUBMIT;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end

            S_FULL:
            begin
                if (out_free)
                begin
                    out_next        = '0;
                    out_next.status = vqda_pkg::ST_FULL;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_SUBMIT:
            begin
                if (out_free)
                begin
                    mem_we                = 1'b1;
                    fm_upd_en             = 1'b1;
                    out_next.status       = vqda_pkg::ST_OK;
                    out_next.desc_index   = 4'(idx_reg[k_reg]);
                    out_next.desc_addr    = wr_addr;
                    out_next.desc_len     = wr_len;
                    out_next.desc_flags   = wr_flags;
                    out_next.desc_next    = 3'(wr_next);
                    out_next.avail_slot   = 3'(slot_reg);
                    out_next.request_type = is_write_reg;
                    out_next.sector       = sector_reg;
                    out_next.last         = (k_reg == 2'(vqda_pkg::CHAIN_LEN - 1));
                    out_valid_next        = 1'b1;
                    if (k_reg == 2'(vqda_pkg::CHAIN_LEN - 1))
                    begin
                        // head posted; slot follows the 16-bit index modulo the size
                        avail_cnt_next = avail_cnt_reg + 16'd1;
                        if ((avail_cnt_reg == 16'hFFFF)
                            || (slot_reg == IDX_W'(QUEUE_SIZE - 1)))
                        begin
                            slot_next = '0;
                        end
                        else
                        begin
                            slot_next = slot_reg + IDX_W'(1);
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end

            S_REL_CHK:
            begin
                if (!cur_in_range || fm_rd_bit)
                begin
                    if (out_free)
                    begin
                        out_next            = '0;
                        out_next.status     = cur_in_range ? vqda_pkg::ST_FREED
                                                           : vqda_pkg::ST_RANGE;
                        out_next.desc_index = 4'(cur_reg);
                        out_next.last       = 1'b1;
                        out_valid_next      = 1'b1;
                        state_next          = S_IDLE;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_REL_OUT;
                end
            end

            S_REL_OUT:
            begin
                if (out_free)
                begin
                    mem_we              = 1'b1;
                    mem_waddr           = cur_reg[IDX_W-1:0];
                    mem_wdata           = '0;
                    fm_upd_en           = 1'b1;
                    fm_upd_idx          = cur_reg[IDX_W-1:0];
                    fm_upd_val          = 1'b1;
                    out_next            = '0;
                    out_next.status     = vqda_pkg::ST_OK;
                    out_next.desc_index = 4'(cur_reg);
                    out_next.desc_flags = rd_flags;
                    out_next.desc_next  = 3'(rd_next);
                    out_next.last       = rd_stop;
                    out_valid_next      = 1'b1;
                    n_next              = n_reg + 3'd1;
                    cur_next            = CUR_W'(rd_next);
                    state_next          = rd_stop ? S_IDLE : S_REL_CHK;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            idx_reg       <= '{default: '0};
            taken_reg     <= '0;
            cur_reg       <= '0;
            n_reg         <= '0;
            is_write_reg  <= 1'b0;
            sector_reg    <= '0;
            data_reg      <= '0;
            avail_cnt_reg <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            idx_reg       <= idx_next;
            taken_reg     <= taken_next;
            cur_reg       <= cur_next;
            n_reg         <= n_next;
            is_write_reg  <= is_write_next;
            sector_reg    <= sector_next;
            data_reg      <= data_next;
            avail_cnt_reg <= avail_cnt_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign fm_mask   = taken_reg;
    assign fm_rd_idx = cur_reg[IDX_W-1:0];

    assign in_ch.ready = (state_reg == S_IDLE);

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_reg.status;
    assign out_ch.desc_index   = out_reg.desc_index;
    assign out_ch.desc_addr    = out_reg.desc_addr;
    assign out_ch.desc_len     = out_reg.desc_len;
    assign out_ch.desc_flags   = out_reg.desc_flags;
    assign out_ch.desc_next    = out_reg.desc_next;
    assign out_ch.avail_slot   = out_reg.avail_slot;
    assign out_ch.request_type = out_reg.request_type;
    assign out_ch.sector       = out_reg.sector;
    assign out_ch.last         = out_reg.last;

`ifndef SYNTH
    a_taken_max: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(taken_reg) <= vqda_pkg::CHAIN_LEN)
        else $error("more than three descriptors reserved");

    a_release_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.func == vqda_pkg::FUNC_RELEASE)
        |=> (state_reg == S_REL_CHK))
        else $error("release transfer did not start the chain walk");

    a_avail_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUBMIT && k_reg == 2'(vqda_pkg::CHAIN_LEN - 1) && out_free)
        |=> (avail_cnt_reg == $past(avail_cnt_reg) + 16'd1))
        else $error("available index did not advance by one");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, slot_reg} < (IDX_W + 1)'(QUEUE_SIZE))
        else $error("available slot past queue size");

    a_read_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (cur_in_range && !fm_rd_bit))
        else $error("descriptor read of a free or out-of-range entry");
`endif

endmodule
`default_nettype wire

[rtl/core/virtqueue_descriptor_allocator_top.sv]
// Top level of the split virtqueue descriptor allocator for a block device.
//
// Driver-side descriptor management for a legacy virtio block queue. A submit
// transfer (func 0) reserves the three lowest free descriptors, writes them as
// header (16 bytes at header_base + 16*head), data (1024 bytes at data_addr)
// and status (1 byte at status_base + 16*head), links them, posts the head to
// the available ring slot and returns three results, the last one flagged.
// With fewer than three free descriptors a single status-1 result comes back
// and nothing changes. A release transfer (func 1) walks the chain from
// head_index, returning one result per descriptor freed; an index past the
// queue or an already free descriptor ends the walk with status 2 or 3. A walk
// stops after eight descriptors. One item is in flight at a time; the input
// is ready again as soon as the last result sits in the output register, even
// if it has not been taken. A submit runs accept, three free-map searches and
// three descriptor writes; a full queue issues its result at the first failed
// search. A release checks each index, reads its descriptor from memory,
// issues its result and writes the entry back; a walk ending on an
// out-of-range or already free index issues that result from the check. The
// free map resets to all free, no clearing pass. Base registers are written
// on cfg_we with cfg_index 0 (header_base) or 1 (status_base); the user must
// do so only while the block is idle, which the block does not enforce.
`default_nettype none
module virtqueue_descriptor_allocator_top #(
    parameter int QUEUE_SIZE = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    vqda_in_if.sink          in_ch,
    vqda_out_if.source       out_ch
);

    localparam int IDX_W  = $clog2(QUEUE_SIZE);
    localparam int DATA_W = 77 + IDX_W;  // addr 64, len 11, flags 2, next

    logic [63:0] header_base_reg;
    logic [63:0] status_base_reg;

    // free map hookup
    logic [QUEUE_SIZE-1:0] fm_mask;
    logic                  fm_found;
    logic [IDX_W-1:0]      fm_pos;
    logic                  fm_upd_en;
    logic [IDX_W-1:0]      fm_upd_idx;
    logic                  fm_upd_val;
    logic [IDX_W-1:0]      fm_rd_idx;
    logic                  fm_rd_bit;

    // descriptor memory hookup
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [DATA_W-1:0]     mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    logic [DATA_W-1:0]     mem_rdata;

    // base address registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_base_reg <= '0;
            status_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vqda_pkg::CFG_HEADER_BASE: header_base_reg <= cfg_wdata;
                vqda_pkg::CFG_STATUS_BASE: status_base_reg <= cfg_wdata;
                default:                   header_base_reg <= header_base_reg;
            endcase
        end
    end

    vqda_free_map #(
        .QUEUE_SIZE (QUEUE_SIZE)
    ) u_free_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .mask    (fm_mask),
        .found   (fm_found),
        .pos     (fm_pos),
        .upd_en  (fm_upd_en),
        .upd_idx (fm_upd_idx),
        .upd_val (fm_upd_val),
        .rd_idx  (fm_rd_idx),
        .rd_bit  (fm_rd_bit)
    );

    vqda_desc_mem #(
        .DEPTH (QUEUE_SIZE),
        .WIDTH (DATA_W)
    ) u_desc_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    vqda_ctrl #(
        .QUEUE_SIZE (QUEUE_SIZE)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .header_base (header_base_reg),
        .status_base (status_base_reg),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .fm_mask     (fm_mask),
        .fm_found    (fm_found),
        .fm_pos      (fm_pos),
        .fm_upd_en   (fm_upd_en),
        .fm_upd_idx  (fm_upd_idx),
        .fm_upd_val  (fm_upd_val),
        .fm_rd_idx   (fm_rd_idx),
        .fm_rd_bit   (fm_rd_bit),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

endmodule
`default_nettype wire

[tb/vqda_scoreboard.sv]
// Scoreboard for the virtqueue descriptor allocator: shadow descriptor table and result check.
module vqda_scoreboard #(
    parameter int QUEUE_SIZE = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    vqda_in_if               in_ch,
    vqda_out_if              out_ch,
    output int               mismatches,
    output int               outstanding
);

    // shadow of the descriptor table and ring state
    logic [63:0] hdr_base;
    logic [63:0] sts_base;
    bit          desc_free [QUEUE_SIZE];
    logic [63:0] desc_addr [QUEUE_SIZE];
    logic [10:0] desc_len  [QUEUE_SIZE];
    logic [1:0]  desc_flags[QUEUE_SIZE];
    logic [2:0]  desc_next [QUEUE_SIZE];
    logic [15:0] avail_idx;

    vqda_pkg::res_t expected_descs[$];
    int             bad_count = 0;

    function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] seen);
        if (want === seen)
            return 1'b1;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
        return 1'b0;
    endfunction

    // three lowest free descriptors become header, data and status
    task automatic predict_submit(input logic wr, input logic [31:0] blk,
                                  input logic [63:0] buf_addr);
        int             picks[3];
        int             found;
        logic [32:0]    sect;
        logic [2:0]     slot;
        vqda_pkg::res_t r;
        found = 0;
        sect  = {blk, 1'b0};
        for (int i = 0; i < QUEUE_SIZE; i++)
        begin
            if (desc_free[i] && found < 3)
            begin
                picks[found] = i;
                found++;
            end
        end
        if (found < 3)
        begin
            r        = '0;
            r.status = vqda_pkg::ST_FULL;
            r.last   = 1'b1;
            expected_descs.push_back(r);
            return;
        end
        foreach (picks[k])
            desc_free[picks[k]] = 1'b0;

        desc_addr[picks[0]]  = hdr_base + 64'(picks[0]) * 16;
        desc_len[picks[0]]   = vqda_pkg::HEADER_LEN;
        desc_flags[picks[0]] = vqda_pkg::FLAG_NEXT;
        desc_next[picks[0]]  = 3'(picks[1]);

        desc_addr[picks[1]]  = buf_addr;
        desc_len[picks[1]]   = vqda_pkg::BLOCK_LEN;
        desc_flags[picks[1]] = (wr ? 2'b00 : vqda_pkg::FLAG_WRITE) | vqda_pkg::FLAG_NEXT;
        desc_next[picks[1]]  = 3'(picks[2]);

        desc_addr[picks[2]]  = sts_base + 64'(picks[0]) * 16;
        desc_len[picks[2]]   = vqda_pkg::STATUS_LEN;
        desc_flags[picks[2]] = vqda_pkg::FLAG_WRITE;
        desc_next[picks[2]]  = 3'd0;

        slot      = 3'(avail_idx % QUEUE_SIZE);
        avail_idx = avail_idx + 16'd1;

        foreach (picks[k])
        begin
            r              = '0;
            r.status       = vqda_pkg::ST_OK;
            r.desc_index   = 4'(picks[k]);
            r.desc_addr    = desc_addr[picks[k]];
            r.desc_len     = desc_len[picks[k]];
            r.desc_flags   = desc_flags[picks[k]];
            r.desc_next    = desc_next[picks[k]];
            r.avail_slot   = slot;
            r.request_type = wr;
            r.sector       = sect;
            r.last         = (k == 2);
            expected_descs.push_back(r);
        end
    endtask

    // walk the chain, freeing as we go; stop on error, end of chain or cap
    task automatic predict_release(input logic [3:0] head);
        int             cur;
        int             walked;
        bit             done;
        logic [1:0]     fl;
        logic [2:0]     nx;
        vqda_pkg::res_t r;
        cur    = head;
        walked = 0;
        done   = 1'b0;
        while (!done)
        begin
            r            = '0;
            r.desc_index = 4'(cur);
            if (cur >= QUEUE_SIZE)
            begin
                r.status = vqda_pkg::ST_RANGE;
                done     = 1'b1;
            end
            else if (desc_free[cur])
            begin
                r.status = vqda_pkg::ST_FREED;
                done     = 1'b1;
            end
            else
            begin
                fl               = desc_flags[cur];
                nx               = desc_next[cur];
                desc_addr[cur]   = '0;
                desc_len[cur]    = '0;
                desc_flags[cur]  = '0;
                desc_next[cur]   = '0;
                desc_free[cur]   = 1'b1;
                walked++;
                r.status     = vqda_pkg::ST_OK;
                r.desc_flags = fl;
                r.desc_next  = nx;
                done         = ((fl & vqda_pkg::FLAG_NEXT) == 2'b00)
                               || (walked >= vqda_pkg::MAX_RESULTS);
                cur          = nx;
            end
            r.last = done;
            expected_descs.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        vqda_pkg::res_t want;
        vqda_pkg::res_t seen;
        int             errs;
        if (!rst_n)
        begin
            hdr_base  = '0;
            sts_base  = '0;
            avail_idx = '0;
            for (int i = 0; i < QUEUE_SIZE; i++)
            begin
                desc_free[i]  = 1'b1;
                desc_addr[i]  = '0;
                desc_len[i]   = '0;
                desc_flags[i] = '0;
                desc_next[i]  = '0;
            end
            expected_descs.delete();
            outstanding <= 0;
        end
        else
        begin
            // results first: they belong to an item accepted earlier
            if (out_ch.valid && out_ch.ready)
            begin
                seen.status       = vqda_pkg::status_t'(out_ch.status);
                seen.desc_index   = out_ch.desc_index;
                seen.desc_addr    = out_ch.desc_addr;
                seen.desc_len     = out_ch.desc_len;
                seen.desc_flags   = out_ch.desc_flags;
                seen.desc_next    = out_ch.desc_next;
                seen.avail_slot   = out_ch.avail_slot;
                seen.request_type = out_ch.request_type;
                seen.sector       = out_ch.sector;
                seen.last         = out_ch.last;
                if (expected_descs.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual index %0h status %0h",
                             $time, seen.desc_index, seen.status);
                    bad_count++;
                end
                else
                begin
                    want = expected_descs.pop_front();
                    errs = 0;
                    errs += !field_ok("status", want.status, seen.status);
                    errs += !field_ok("desc_index", want.desc_index, seen.desc_index);
                    errs += !field_ok("desc_addr", want.desc_addr, seen.desc_addr);
                    errs += !field_ok("desc_len", want.desc_len, seen.desc_len);
                    errs += !field_ok("desc_flags", want.desc_flags, seen.desc_flags);
                    errs += !field_ok("desc_next", want.desc_next, seen.desc_next);
                    errs += !field_ok("avail_slot", want.avail_slot, seen.avail_slot);
                    errs += !field_ok("request_type", want.request_type, seen.request_type);
                    errs += !field_ok("sector", want.sector, seen.sector);
                    errs += !field_ok("last", want.last, seen.last);
                    if (errs != 0)
                        bad_count++;
                end
            end

            if (cfg_we)
            begin
                if (cfg_index == vqda_pkg::CFG_HEADER_BASE)
                    hdr_base = cfg_wdata;
                else
                    sts_base = cfg_wdata;
            end

            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.func == vqda_pkg::FUNC_SUBMIT)
                    predict_submit(in_ch.is_write, in_ch.block_number, in_ch.data_addr);
                else
                    predict_release(in_ch.head_index);
            end
            outstanding <= expected_descs.size();
        end
        mismatches <= bad_count;
    end

endmodule

[tb/tb_virtqueue_descriptor_allocator_top.sv]
// Testbench top for the virtqueue descriptor allocator: stimulus, flow control and verdict.
module tb_virtqueue_descriptor_allocator_top;

    localparam int QSIZE       = 8;
    localparam int CYCLE_LIMIT = 200000;
    // longest walk is eight descriptors, each checked, read and written back, plus accept
    localparam int SETTLE_CYCLES = 24;
    localparam int RX_HOLD_CYCLES = 150;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_wdata;

    vqda_in_if  req_bus ();
    vqda_out_if res_bus ();

    int mismatches;
    int outstanding;
    int cycle_count;

    // flow-control knobs, set by the stimulus process
    bit no_idle = 1'b0;
    bit hold_request = 1'b0;

    // head indexes seen in submit results; used to build well-formed releases
    logic [3:0] live_heads[$];

    virtqueue_descriptor_allocator_top #(
        .QUEUE_SIZE (QSIZE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (req_bus),
        .out_ch    (res_bus)
    );

    vqda_scoreboard #(
        .QUEUE_SIZE (QSIZE)
    ) u_scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_ch       (req_bus),
        .out_ch      (res_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Result side. Random stalls, a calm stretch when no_idle is set, and one
    // long hold-off so the block backs up and stalls its input.
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        res_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else if (no_idle)
                res_bus.ready <= 1'b1;
            else
                res_bus.ready <= ($urandom_range(99) >= 28);
        end
    end

    // Learn chain heads: a successful submit reports its header descriptor
    // with the 16-byte header length.
    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready && res_bus.status == vqda_pkg::ST_OK &&
            res_bus.desc_len == vqda_pkg::HEADER_LEN)
            live_heads.push_back(res_bus.desc_index);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // One transfer on the request channel. Valid stays high into the next
    // call unless that call opens a gap, so valid is never dropped and
    // raised in the same step.
    task automatic send_item(input logic fn, input logic wr, input logic [31:0] blk,
                             input logic [63:0] buf_addr, input logic [3:0] head);
        int gap;
        gap = 0;
        if (!no_idle)
        begin
            while ($urandom_range(99) < 28)
                gap++;
        end
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.func         <= fn;
        req_bus.is_write     <= wr;
        req_bus.block_number <= blk;
        req_bus.data_addr    <= buf_addr;
        req_bus.head_index   <= head;
        do
            @(posedge clk);
        while (!req_bus.ready);
    endtask

    // fields unused by the function still get random values
    task automatic post_request(input logic wr, input logic [31:0] blk,
                                input logic [63:0] buf_addr);
        send_item(vqda_pkg::FUNC_SUBMIT, wr, blk, buf_addr, 4'($urandom));
    endtask

    task automatic release_chain(input logic [3:0] head);
        send_item(vqda_pkg::FUNC_RELEASE, 1'($urandom), $urandom, rand64(), head);
    endtask

    // Sender goes quiet until every expected result has come back, then
    // lets the block finish any trailing write-back.
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both base registers, back to back; only called with the block idle.
    task automatic set_bases(input logic [63:0] hdr, input logic [63:0] sts);
        cfg_we    <= 1'b1;
        cfg_index <= vqda_pkg::CFG_HEADER_BASE;
        cfg_wdata <= hdr;
        @(posedge clk);
        cfg_index <= vqda_pkg::CFG_STATUS_BASE;
        cfg_wdata <= sts;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly submits and releases of live chains; the rest is stray
    // releases of random heads, in range or anywhere in the 4-bit field.
    task automatic random_item();
        int         pick;
        int         k;
        logic [3:0] head;
        pick = $urandom_range(99);
        if (pick < 45)
            post_request(1'($urandom), $urandom, rand64());
        else if (pick < 85 && live_heads.size() > 0)
        begin
            k    = $urandom_range(live_heads.size() - 1);
            head = live_heads[k];
            live_heads.delete(k);
            release_chain(head);
        end
        else if (pick < 93)
            release_chain(4'($urandom_range(QSIZE - 1)));
        else
            release_chain(4'($urandom_range(15)));
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = vqda_pkg::CFG_HEADER_BASE;
        cfg_wdata            = '0;
        req_bus.valid        = 1'b0;
        req_bus.func         = vqda_pkg::FUNC_SUBMIT;
        req_bus.is_write     = 1'b0;
        req_bus.block_number = '0;
        req_bus.data_addr    = '0;
        req_bus.head_index   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, bases at opposite extremes.
        set_bases(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        post_request(1'b0, 32'h0, 64'h0);                                // descs 0,1,2
        post_request(1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);      // descs 3,4,5
        post_request(1'b0, 32'h1234_5678, 64'h0000_1000_0000_0400);      // queue full
        release_chain(4'd15);                                            // out of range
        release_chain(4'd6);                                             // never allocated
        release_chain(4'd0);                                             // full chain of three
        release_chain(4'd4);                                             // from mid-chain
        release_chain(4'd3);                                             // frees 3, then hits free 4

        // Staircase: releasing from the data descriptor leaves the header's
        // stale link behind, so the next request extends one long chain.
        // Ends with all eight descriptors linked from 0: the longest walk.
        for (int s = 0; s < 5; s++)
        begin
            post_request(1'(s), 32'h8000_0000 | 32'(s), rand64());
            release_chain(4'(s + 1));
        end
        post_request(1'b1, 32'h7FFF_FFFF, 64'h8000_0000_0000_0000);
        release_chain(4'd0);

        // Random phases, each starting from an idle block with new bases.
        for (int ph = 0; ph < 4; ph++)
        begin
            drain_results();
            live_heads.delete();
            case (ph)
                0:       set_bases(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
                2:       set_bases(64'h8000_0000_0000_0000, rand64());
                default: set_bases(rand64(), rand64());
            endcase
            no_idle = (ph == 1);       // one long stretch with no idling
            if (ph == 2)
                hold_request = 1'b1;   // receiver stalls while we keep sending
            repeat (22) random_item();
        end
        drain_results();

        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/vqda_pkg.sv
rtl/core/vqda_ifs.sv
rtl/core/vqda_desc_mem.sv
rtl/core/vqda_free_map.sv
rtl/core/vqda_ctrl.sv
rtl/core/virtqueue_descriptor_allocator_top.sv
tb/vqda_scoreboard.sv
tb/tb_virtqueue_descriptor_allocator_top.sv
